// ----- hdl/quaternion_to_rotation_matrix_unit_macros.svh -----
// Assertion helpers for the RTL file that checks itself.
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define QRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, gated by reset.
`define QRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/qrm_pkg.sv -----
package qrm_pkg;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam int OUT_FRAC = OUT_W - 2;
    localparam int PROD_W   = 2 * IN_W;
    localparam int NORM_W   = 2 * IN_W + 1;
    localparam int SUM_W    = PROD_W + 3;
    localparam int STEPS    = OUT_W;
    localparam int N_ELEM   = 9;

    localparam logic signed [OUT_W-1:0] ONE_Q = OUT_W'(1) <<< OUT_FRAC;
    localparam logic signed [OUT_W-1:0] MAX_Q = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] MIN_Q = {1'b1, {(OUT_W-1){1'b0}}};

    // Lane order matches the result fields.
    localparam int E_M00 = 0;
    localparam int E_M10 = 1;
    localparam int E_M20 = 2;
    localparam int E_M01 = 3;
    localparam int E_M11 = 4;
    localparam int E_M21 = 5;
    localparam int E_M02 = 6;
    localparam int E_M12 = 7;
    localparam int E_M22 = 8;

    typedef struct packed {
        logic signed [IN_W-1:0] quat_x;
        logic signed [IN_W-1:0] quat_y;
        logic signed [IN_W-1:0] quat_z;
        logic signed [IN_W-1:0] quat_w;
    } quat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] m00;
        logic signed [OUT_W-1:0] m10;
        logic signed [OUT_W-1:0] m20;
        logic signed [OUT_W-1:0] m01;
        logic signed [OUT_W-1:0] m11;
        logic signed [OUT_W-1:0] m21;
        logic signed [OUT_W-1:0] m02;
        logic signed [OUT_W-1:0] m12;
        logic signed [OUT_W-1:0] m22;
        logic                    zero_norm;
    } rot_t;

endpackage

// ----- hdl/qrm_div.sv -----
// Pipelined restoring divider: round(num * 2^OUT_FRAC / norm), one bit per stage.
module qrm_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic                            num_neg,
    input  logic [qrm_pkg::NORM_W-1:0]      num_mag,
    input  logic [qrm_pkg::NORM_W-1:0]      norm,
    output logic [qrm_pkg::OUT_W-1:0]       q_out,
    output logic                            neg_out
);

    localparam int NW = qrm_pkg::NORM_W;
    localparam int QW = qrm_pkg::OUT_W;
    localparam int ST = qrm_pkg::STEPS;

    logic [NW-1:0] rem_reg  [ST-1];
    logic [NW-1:0] norm_reg [ST-1];
    logic [QW-1:0] q_reg    [ST];
    logic          neg_reg  [ST];

    for (genvar k = 0; k < ST; k++)
    begin : g_step
        logic [NW:0]   rem_in;
        logic [NW-1:0] n_cur;
        logic [NW:0]   diff;
        logic          ge;
        logic [QW-1:0] q_next;
        logic          neg_next;

        if (k == 0)
        begin : g_first
            assign rem_in   = {1'b0, num_mag};
            assign n_cur    = norm;
            assign neg_next = num_neg;
            assign q_next   = QW'(ge);
        end
        else
        begin : g_rest
            assign rem_in   = {rem_reg[k-1], 1'b0};
            assign n_cur    = norm_reg[k-1];
            assign neg_next = neg_reg[k-1];
            if (k == ST - 1)
            begin : g_round
                // final bit rounds half away from zero
                assign q_next = q_reg[k-1] + QW'(ge);
            end
            else
            begin : g_mid
                assign q_next = {q_reg[k-1][QW-2:0], ge};
            end
        end

        assign diff = rem_in - {1'b0, n_cur};
        assign ge   = (rem_in >= {1'b0, n_cur});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= q_next;
                neg_reg[k] <= neg_next;
            end
        end

        if (k < ST - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? diff[NW-1:0] : rem_in[NW-1:0];
                    norm_reg[k] <= n_cur;
                end
            end
        end
    end

    assign q_out   = q_reg[ST-1];
    assign neg_out = neg_reg[ST-1];

endmodule

// ----- hdl/quaternion_to_rotation_matrix_unit.sv -----
// Quaternion to 3x3 rotation matrix.
// Input channel in_valid/in_ready/in_data carries one quaternion (Q4.12 x, y, z, w);
// output channel out_valid/out_ready/out_data carries the nine Q2.14 elements and
// the zero_norm flag. A transfer happens when valid and ready are both high.
// Throughput: one quaternion per cycle, sustained while out_ready stays high.
// Pipeline: three stages of unpack, products and sums, sixteen stages of
// restoring division (one quotient bit each, nine lanes side by side), then
// the output register.
// The division chain sets the depth.
// An all-zero quaternion yields the identity matrix with zero_norm set.
// Reset clears all valid bits; the pipeline is empty after rst_n rises.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
`include "quaternion_to_rotation_matrix_unit_macros.svh"

module quaternion_to_rotation_matrix_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qrm_pkg::quat_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output qrm_pkg::rot_t  out_data
);

    localparam int IW = qrm_pkg::IN_W;
    localparam int OW = qrm_pkg::OUT_W;
    localparam int PW = qrm_pkg::PROD_W;
    localparam int NW = qrm_pkg::NORM_W;
    localparam int SW = qrm_pkg::SUM_W;
    localparam int ST = qrm_pkg::STEPS;
    localparam int NE = qrm_pkg::N_ELEM;

    logic adv;

    // stage 1: sign and magnitude
    logic          s1_vld_reg;
    logic          s1_neg_reg [4];
    logic [IW-1:0] s1_mag_reg [4];
    logic [IW-1:0] in_comp    [4];

    // stage 2: products (0..3 squares x y z w; 4..9 xy yz zx xw yw zw)
    logic          s2_vld_reg;
    logic [PW-1:0] s2_prod_reg [10];
    logic          s2_neg_reg  [10];

    // stage 3: numerators and norm
    logic          s3_vld_reg;
    logic          s3_zero_reg;
    logic [NW-1:0] s3_norm_reg;
    logic          s3_neg_reg [NE];
    logic [NW-1:0] s3_mag_reg [NE];
    logic signed [SW-1:0] sp [10];
    logic signed [SW-1:0] num_s [NE];
    logic [NW-1:0] norm_next;

    // division stages
    logic [ST-1:0] dv_vld_reg;
    logic [ST-1:0] dz_reg;
    logic [OW-1:0] q_lane   [NE];
    logic          neg_lane [NE];

    // output register
    logic                 out_vld_reg;
    logic                 out_zero_reg;
    logic signed [OW-1:0] out_elem_reg [NE];

    function automatic logic signed [SW-1:0] to_signed(logic neg, logic [PW-1:0] mag);
        logic signed [SW-1:0] v;
        v = $signed({{(SW-PW){1'b0}}, mag});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [OW-1:0] finish(logic neg, logic [OW-1:0] q,
                                                    logic zero, logic diag);
        logic signed [OW+1:0] v;
        logic signed [OW-1:0] r;
        v = $signed({2'b00, q});
        if (neg)
        begin
            v = -v;
        end
        if (v > $signed({{2{qrm_pkg::MAX_Q[OW-1]}}, qrm_pkg::MAX_Q}))
        begin
            r = qrm_pkg::MAX_Q;
        end
        else if (v < $signed({{2{qrm_pkg::MIN_Q[OW-1]}}, qrm_pkg::MIN_Q}))
        begin
            r = qrm_pkg::MIN_Q;
        end
        else
        begin
            r = v[OW-1:0];
        end
        if (zero)
        begin
            r = diag ? qrm_pkg::ONE_Q : '0;
        end
        return r;
    endfunction

    // advance the whole pipeline unless a finished result is held
    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv;

    assign in_comp[0] = in_data.quat_x;
    assign in_comp[1] = in_data.quat_y;
    assign in_comp[2] = in_data.quat_z;
    assign in_comp[3] = in_data.quat_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= in_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            dv_vld_reg  <= {dv_vld_reg[ST-2:0], s3_vld_reg};
            out_vld_reg <= dv_vld_reg[ST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s1_neg_reg[i] <= in_comp[i][IW-1];
                s1_mag_reg[i] <= in_comp[i][IW-1] ? IW'(-in_comp[i]) : in_comp[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s2_prod_reg[i] <= PW'(s1_mag_reg[i]) * PW'(s1_mag_reg[i]);
                s2_neg_reg[i]  <= 1'b0;
            end
            s2_prod_reg[4] <= PW'(s1_mag_reg[0]) * PW'(s1_mag_reg[1]);
            s2_neg_reg[4]  <= s1_neg_reg[0] ^ s1_neg_reg[1];
            s2_prod_reg[5] <= PW'(s1_mag_reg[1]) * PW'(s1_mag_reg[2]);
            s2_neg_reg[5]  <= s1_neg_reg[1] ^ s1_neg_reg[2];
            s2_prod_reg[6] <= PW'(s1_mag_reg[2]) * PW'(s1_mag_reg[0]);
            s2_neg_reg[6]  <= s1_neg_reg[2] ^ s1_neg_reg[0];
            s2_prod_reg[7] <= PW'(s1_mag_reg[0]) * PW'(s1_mag_reg[3]);
            s2_neg_reg[7]  <= s1_neg_reg[0] ^ s1_neg_reg[3];
            s2_prod_reg[8] <= PW'(s1_mag_reg[1]) * PW'(s1_mag_reg[3]);
            s2_neg_reg[8]  <= s1_neg_reg[1] ^ s1_neg_reg[3];
            s2_prod_reg[9] <= PW'(s1_mag_reg[2]) * PW'(s1_mag_reg[3]);
            s2_neg_reg[9]  <= s1_neg_reg[2] ^ s1_neg_reg[3];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            sp[i] = to_signed(s2_neg_reg[i], s2_prod_reg[i]);
        end
        num_s[qrm_pkg::E_M00] = sp[3] + sp[0] - sp[1] - sp[2];
        num_s[qrm_pkg::E_M11] = sp[3] + sp[1] - sp[2] - sp[0];
        num_s[qrm_pkg::E_M22] = sp[3] + sp[2] - sp[0] - sp[1];
        num_s[qrm_pkg::E_M10] = (sp[4] + sp[9]) <<< 1;
        num_s[qrm_pkg::E_M01] = (sp[4] - sp[9]) <<< 1;
        num_s[qrm_pkg::E_M20] = (sp[6] - sp[8]) <<< 1;
        num_s[qrm_pkg::E_M02] = (sp[6] + sp[8]) <<< 1;
        num_s[qrm_pkg::E_M21] = (sp[5] + sp[7]) <<< 1;
        num_s[qrm_pkg::E_M12] = (sp[5] - sp[7]) <<< 1;
        norm_next = NW'(s2_prod_reg[0]) + NW'(s2_prod_reg[1])
                  + NW'(s2_prod_reg[2]) + NW'(s2_prod_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_norm_reg <= norm_next;
            s3_zero_reg <= (norm_next == '0);
            for (int i = 0; i < NE; i++)
            begin
                s3_neg_reg[i] <= num_s[i][SW-1];
                s3_mag_reg[i] <= num_s[i][SW-1] ? NW'(-num_s[i]) : NW'(num_s[i]);
            end
        end
    end

    for (genvar e = 0; e < NE; e++)
    begin : g_lane
        qrm_div u_div (
            .clk     (clk),
            .en      (adv),
            .num_neg (s3_neg_reg[e]),
            .num_mag (s3_mag_reg[e]),
            .norm    (s3_norm_reg),
            .q_out   (q_lane[e]),
            .neg_out (neg_lane[e])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dz_reg       <= {dz_reg[ST-2:0], s3_zero_reg};
            out_zero_reg <= dz_reg[ST-1];
            for (int i = 0; i < NE; i++)
            begin
                out_elem_reg[i] <= finish(neg_lane[i], q_lane[i], dz_reg[ST-1],
                                          (i == qrm_pkg::E_M00) || (i == qrm_pkg::E_M11)
                                          || (i == qrm_pkg::E_M22));
            end
        end
    end

    assign out_valid          = out_vld_reg;
    assign out_data.m00       = out_elem_reg[qrm_pkg::E_M00];
    assign out_data.m10       = out_elem_reg[qrm_pkg::E_M10];
    assign out_data.m20       = out_elem_reg[qrm_pkg::E_M20];
    assign out_data.m01       = out_elem_reg[qrm_pkg::E_M01];
    assign out_data.m11       = out_elem_reg[qrm_pkg::E_M11];
    assign out_data.m21       = out_elem_reg[qrm_pkg::E_M21];
    assign out_data.m02       = out_elem_reg[qrm_pkg::E_M02];
    assign out_data.m12       = out_elem_reg[qrm_pkg::E_M12];
    assign out_data.m22       = out_elem_reg[qrm_pkg::E_M22];
    assign out_data.zero_norm = out_zero_reg;

    `QRM_ASSERT_IMP(a_zero_identity, out_valid && out_data.zero_norm, out_data.m00 == qrm_pkg::ONE_Q && out_data.m11 == qrm_pkg::ONE_Q && out_data.m22 == qrm_pkg::ONE_Q && out_data.m10 == '0 && out_data.m12 == '0)
    `QRM_ASSERT_IMP(a_diag_range, out_valid, out_data.m11 <= qrm_pkg::ONE_Q && out_data.m11 >= -qrm_pkg::ONE_Q)
    `QRM_ASSERT_NEXT(a_stall_hold, !adv && s3_vld_reg, s3_vld_reg && $stable(s3_norm_reg))
    `QRM_ASSERT_IMP(a_zero_from_norm, s3_vld_reg, s3_zero_reg == (s3_norm_reg == '0))

endmodule

// ----- dv/qrm_checker.sv -----
module qrm_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  qrm_pkg::quat_t in_data,
    input  logic           out_valid,
    input  logic           out_ready,
    input  qrm_pkg::rot_t  out_data,
    output int             fail_count,
    output int             pending
);

    qrm_pkg::rot_t matrix_q[$];

    // Exact num * 2^OUT_FRAC / n, rounded half away from zero.
    function automatic logic signed [qrm_pkg::OUT_W-1:0] scale_elem(longint num, longint n);
        longint mag;
        longint q;
        longint v;
        mag = (num < 0) ? -num : num;
        q = ((mag << (qrm_pkg::OUT_FRAC + 1)) / n + 1) >>> 1;
        v = (num < 0) ? -q : q;
        if (v > longint'(qrm_pkg::MAX_Q))
            v = longint'(qrm_pkg::MAX_Q);
        if (v < longint'(qrm_pkg::MIN_Q))
            v = longint'(qrm_pkg::MIN_Q);
        return v[qrm_pkg::OUT_W-1:0];
    endfunction

    function automatic qrm_pkg::rot_t quat_to_matrix(qrm_pkg::quat_t q);
        qrm_pkg::rot_t r;
        longint x;
        longint y;
        longint z;
        longint w;
        longint n;
        x = q.quat_x;
        y = q.quat_y;
        z = q.quat_z;
        w = q.quat_w;
        n = x*x + y*y + z*z + w*w;
        r = '0;
        if (n == 0)
        begin
            r.m00 = qrm_pkg::ONE_Q;
            r.m11 = qrm_pkg::ONE_Q;
            r.m22 = qrm_pkg::ONE_Q;
            r.zero_norm = 1'b1;
            return r;
        end
        r.m00 = scale_elem(w*w + x*x - y*y - z*z, n);
        r.m11 = scale_elem(w*w + y*y - z*z - x*x, n);
        r.m22 = scale_elem(w*w + z*z - x*x - y*y, n);
        r.m10 = scale_elem(2 * (x*y + z*w), n);
        r.m01 = scale_elem(2 * (x*y - z*w), n);
        r.m20 = scale_elem(2 * (z*x - y*w), n);
        r.m02 = scale_elem(2 * (z*x + y*w), n);
        r.m21 = scale_elem(2 * (y*z + x*w), n);
        r.m12 = scale_elem(2 * (y*z - x*w), n);
        return r;
    endfunction

    task automatic cmp_field(string name, logic [qrm_pkg::OUT_W-1:0] exp_v,
                             logic [qrm_pkg::OUT_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        qrm_pkg::rot_t e;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                matrix_q.push_back(quat_to_matrix(in_data));
            if (out_valid && out_ready)
            begin
                if (matrix_q.size() == 0)
                begin
                    $error("result transfer with no matrix expected");
                    fail_count++;
                end
                else
                begin
                    e = matrix_q.pop_front();
                    cmp_field("m00", e.m00, out_data.m00);
                    cmp_field("m10", e.m10, out_data.m10);
                    cmp_field("m20", e.m20, out_data.m20);
                    cmp_field("m01", e.m01, out_data.m01);
                    cmp_field("m11", e.m11, out_data.m11);
                    cmp_field("m21", e.m21, out_data.m21);
                    cmp_field("m02", e.m02, out_data.m02);
                    cmp_field("m12", e.m12, out_data.m12);
                    cmp_field("m22", e.m22, out_data.m22);
                    cmp_field("zero_norm", {{(qrm_pkg::OUT_W-1){1'b0}}, e.zero_norm},
                              {{(qrm_pkg::OUT_W-1){1'b0}}, out_data.zero_norm});
                end
            end
        end
        pending = matrix_q.size();
    end
endmodule

// ----- dv/tb_quaternion_to_rotation_matrix_unit.sv -----
module tb_quaternion_to_rotation_matrix_unit;

    localparam int N_RANDOM   = 450;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN      = 40;
    localparam int IW         = qrm_pkg::IN_W;

    localparam logic [IW-1:0] IN_MIN = {1'b1, {(IW-1){1'b0}}};
    localparam logic [IW-1:0] IN_MAX = {1'b0, {(IW-1){1'b1}}};

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    qrm_pkg::quat_t in_data;
    logic out_valid;
    logic out_ready;
    qrm_pkg::rot_t out_data;
    int fail_count;
    int pending;
    int idle_cycles;
    bit calm;

    quaternion_to_rotation_matrix_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    qrm_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls at random, except during the calm stretch.
    always @(negedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);

    // Watchdog: count cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [IW-1:0] rand_comp(int mode);
        case (mode)
            0: return IW'($urandom());
            1: return IW'(int'($urandom_range(15)) - 8);
            2: return {IW{1'b0}};
            default: return $urandom_range(1) ? IN_MIN : IN_MAX;
        endcase
    endfunction

    // Drop valid while idling; keep it high across back-to-back transfers.
    task automatic send_quat(logic [IW-1:0] x, logic [IW-1:0] y,
                             logic [IW-1:0] z, logic [IW-1:0] w);
        while (!calm && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {x, y, z, w};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        calm = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero quaternion, unit axes, extremes, mixed signs.
        send_quat(0, 0, 0, 0);
        send_quat(16'h1000, 0, 0, 0);
        send_quat(0, 16'h1000, 0, 0);
        send_quat(0, 0, 16'h1000, 0);
        send_quat(0, 0, 0, 16'h1000);
        send_quat(IN_MIN, 0, 0, 0);
        send_quat(0, 0, 0, IN_MIN);
        send_quat(IN_MIN, IN_MIN, IN_MIN, IN_MIN);
        send_quat(IN_MAX, IN_MAX, IN_MAX, IN_MAX);
        send_quat(IN_MIN, IN_MAX, IN_MIN, IN_MAX);
        send_quat(IN_MAX, IN_MIN, IN_MAX, IN_MIN);
        send_quat(1, 0, 0, 0);
        send_quat(16'hFFFF, 0, 0, 0);
        send_quat(1, 1, 1, 1);
        send_quat(16'hFFFF, 1, 16'hFFFF, 1);
        send_quat(16'h0B50, 0, 0, 16'h0B50);
        send_quat(0, 16'hF4B0, 0, 16'h0B50);
        send_quat(16'h0800, 16'h0800, 16'h0800, 16'h0800);
        send_quat(16'hAAAA, 16'h5555, 16'h3333, 16'hCCCC);
        send_quat(0, 0, 0, 0);
        in_valid <= 1'b0;

        // Hold off until every expected matrix has arrived.
        while (pending != 0)
            @(negedge clk);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 150 && i < 230);
            if ($urandom_range(99) < 80)
                send_quat(IW'($urandom()), IW'($urandom()), IW'($urandom()), IW'($urandom()));
            else
                send_quat(rand_comp($urandom_range(3)), rand_comp($urandom_range(3)),
                          rand_comp($urandom_range(3)), rand_comp($urandom_range(3)));
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
